// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: command and status
// codes, field widths and the result record.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	localparam int OCC_W   = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT   = 3'd0,
		CMD_PUSH_BACK    = 3'd1,
		CMD_REMOVE_FRONT = 3'd2,
		CMD_REMOVE_BACK  = 3'd3,
		CMD_DUMP         = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_DUMP = 1'b1
	} fsm_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] data;
		logic                      is_last;
		logic [1:0]                status;
		logic [OCC_W-1:0]          occupancy;
	} rsp_t;

endpackage

// ----- rtl/deq_req_if.sv -----
// ----------------------------------------------------------------------------
// deq_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface deq_req_if;
	import deq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [VALUE_W-1:0] value;
	logic [COUNT_W-1:0]        remove_count;

	modport source (output valid, output cmd, output value, output remove_count,
		input ready);
	modport sink (input valid, input cmd, input value, input remove_count,
		output ready);
endinterface

// ----- rtl/deq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// deq_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
	import deq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] data;
	logic                      is_last;
	logic [1:0]                status;
	logic [OCC_W-1:0]          occupancy;

	modport source (output valid, output data, output is_last, output status,
		output occupancy, input ready);
	modport sink (input valid, input data, input is_last, input status,
		input occupancy, output ready);
endinterface

// ----- rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Command sequencer: ring pointers, entry count, RAM addressing and the
// dump walk.
// ----------------------------------------------------------------------------
module deq_ctrl #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [deq_pkg::CMD_W-1:0]         cmd,
	input  logic signed [deq_pkg::VALUE_W-1:0] value,
	input  logic [deq_pkg::COUNT_W-1:0]       remove_count,
	input  logic                              slot_free,
	output logic                              res_valid,
	output deq_pkg::rsp_t                     res,
	output logic                              ram_we,
	output logic [$clog2(DEPTH)-1:0]          ram_waddr,
	output logic [DATA_WIDTH-1:0]             ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(DEPTH)-1:0]          ram_raddr,
	input  logic [DATA_WIDTH-1:0]             ram_rdata
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	fsm_t          state_q, state_d;
	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] cursor_q, cursor_d;
	logic [CW-1:0] remain_q, remain_d;

	logic                accept;
	logic                full;
	logic                empty;
	logic [COUNT_W-1:0]  n_clamped;
	logic [AW-1:0]       front_dec;
	logic [AW-1:0]       back_addr;
	logic [AW-1:0]       front_adv;
	logic [AW-1:0]       cursor_inc;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
		input logic [CW-1:0] b);
		logic [SW-1:0] sum;
		sum = SW'(a) + SW'(b);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign req_ready = (state_q == FSM_IDLE) && slot_free;
	assign accept  = req_valid && req_ready;

	assign n_clamped  = (remove_count > COUNT_W'(count_q)) ? COUNT_W'(count_q)
		: remove_count;
	assign front_dec  = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign back_addr  = ring_add(front_q, count_q);
	assign front_adv  = ring_add(front_q, n_clamped[CW-1:0]);
	assign cursor_inc = ring_add(cursor_q, CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept && cmd == CMD_DUMP && !empty) begin
					state_d = FSM_DUMP;
				end
			end
			FSM_DUMP: begin
				if (slot_free && remain_q == CW'(1)) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		front_d   = front_q;
		count_d   = count_q;
		cursor_d  = cursor_q;
		remain_d  = remain_q;
		ram_we    = 1'b0;
		ram_waddr = back_addr;
		ram_wdata = DATA_WIDTH'(value);
		ram_re    = 1'b0;
		ram_raddr = front_q;
		res_valid = 1'b0;
		res.data      = '0;
		res.is_last   = 1'b1;
		res.status    = ST_OK;
		res.occupancy = OCC_W'(count_q);

		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					res_valid = 1'b1;
					unique case (cmd_t'(cmd))
						CMD_PUSH_FRONT: begin
							if (full) begin
								res.status = ST_FULL;
							end else begin
								front_d   = front_dec;
								count_d   = count_q + CW'(1);
								ram_we    = 1'b1;
								ram_waddr = front_dec;
							end
						end
						CMD_PUSH_BACK: begin
							if (full) begin
								res.status = ST_FULL;
							end else begin
								count_d   = count_q + CW'(1);
								ram_we    = 1'b1;
								ram_waddr = back_addr;
							end
						end
						CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
							if (remove_count > COUNT_W'(count_q)) begin
								res.status = ST_UNDERFLOW;
							end
							count_d = count_q - n_clamped[CW-1:0];
							if (cmd_t'(cmd) == CMD_REMOVE_FRONT) begin
								front_d = front_adv;
							end
						end
						CMD_DUMP: begin
							if (empty) begin
								res.status = ST_EMPTY;
							end else begin
								// first read goes out now; results come from the dump state once the slot is free
								res_valid = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = front_q;
								cursor_d  = front_q;
								remain_d  = count_q;
							end
						end
						default: ;
					endcase
					res.occupancy = OCC_W'(count_d);
				end
			end
			FSM_DUMP: begin
				if (slot_free) begin
					res_valid   = 1'b1;
					res.data    = VALUE_W'($signed(ram_rdata));
					res.is_last = (remain_q == CW'(1));
					remain_d    = remain_q - CW'(1);
					if (remain_q != CW'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = cursor_inc;
						cursor_d  = cursor_inc;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			front_q  <= '0;
			count_q  <= '0;
			cursor_q <= '0;
			remain_q <= '0;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
			remain_q <= remain_d;
		end
	end

endmodule

// ----- rtl/double_ended_queue.sv -----
// A bounded double-ended queue of DEPTH signed words held in a ring buffer in
// one RAM. Push front, push back, remove front, remove back and unused command
// codes each give one status transaction; they can follow one another every
// cycle as long as the result side keeps taking results. A dump first issues
// the read of the front entry, then reads the entries out in turn through the
// RAM's single registered read port, one read in flight at a time; no new
// command is taken until the last entry has gone into the output register.
// Stored words keep DATA_WIDTH bits and come back sign-extended to 32 bits.
// The RAM needs no clearing after reset; entries are read only once written.
// ----------------------------------------------------------------------------
// double_ended_queue
// Top level: sequencer, entry RAM and the output register.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                  slot_free;
	logic                  res_valid;
	rsp_t                  res;
	logic                  out_valid_q;
	rsp_t                  out_q;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign slot_free = !out_valid_q || rsp.ready;

	deq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_ready    (req.ready),
		.cmd          (req.cmd),
		.value        (req.value),
		.remove_count (req.remove_count),
		.slot_free    (slot_free),
		.res_valid    (res_valid),
		.res          (res),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.data      = out_q.data;
	assign rsp.is_last   = out_q.is_last;
	assign rsp.status    = out_q.status;
	assign rsp.occupancy = out_q.occupancy;

endmodule

// ----- rtl/deq_checker.sv -----
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker #(
	parameter int DEPTH = 64
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [deq_pkg::VALUE_W-1:0] rsp_data,
	input logic                               rsp_is_last,
	input logic [1:0]                         rsp_status,
	input logic [deq_pkg::OCC_W-1:0]          rsp_occupancy
);
	import deq_pkg::*;

	// a stalled result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
		&& $stable(rsp_is_last) && $stable(rsp_status) && $stable(rsp_occupancy))
		else $error("result changed while stalled");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_occupancy <= OCC_W'(DEPTH))
		else $error("occupancy above depth");

	// mid-dump results are ok and come from a nonempty queue
	a_dump_mid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_is_last |-> rsp_status == ST_OK && rsp_occupancy != '0)
		else $error("bad mid-dump result");

	// no command is taken while a dump is still streaming
	a_no_cmd_mid_dump: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_is_last |-> !(req_valid && req_ready))
		else $error("command accepted during dump");

	a_empty_dump: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_last && rsp_data == '0
		&& rsp_occupancy == '0)
		else $error("bad empty-dump result");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_data      (rsp.data),
	.rsp_is_last   (rsp.is_last),
	.rsp_status    (rsp.status),
	.rsp_occupancy (rsp.occupancy)
);
